// ----- rtl/core/lru_write_back_sector_cache_defines.svh -----
// Assertion macros for the sector cache checker.
`ifndef LRU_WRITE_BACK_SECTOR_CACHE_DEFINES_SVH
`define LRU_WRITE_BACK_SECTOR_CACHE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LRUWB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LRUWB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/lruwb_pkg.sv -----
// Shared constants and types of the LRU write-back sector cache controller.
`timescale 1ns / 1ps

package lruwb_pkg;

    localparam int ENTRIES_DEF  = 64;
    localparam int SECTOR_BYTES = 512;

    localparam int OP_W     = 2;
    localparam int SECTOR_W = 32;
    localparam int LEN_W    = 10;
    localparam int KIND_W   = 2;
    localparam int EIDX_W   = 6;
    localparam int CNT_W    = 32;

    typedef enum logic [OP_W-1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_FLUSH = 2'd2,
        OP_INVAL = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_DONE  = 2'd0,
        KIND_WB    = 2'd1,
        KIND_FETCH = 2'd2
    } kind_t;

endpackage

// ----- rtl/core/lru_write_back_sector_cache.sv -----
// Top level of the fully associative LRU write-back sector cache controller.
`timescale 1ns / 1ps

// Tag and replacement controller for a fully associative write-back sector
// cache of ENTRIES entries. Each request is a read, write, flush or invalidate,
// and it produces one or more responses: writeback and fetch commands followed
// by a completion, writebacks the last of which closes a flush, or a done. One
// request is handled at a time and req_stall stays high until its last response
// has been loaded into the output register. The tag store and the recency list
// each sit in a RAM with one read port, and a single comparator walks them one
// entry per cycle: a read or write runs a tag search, then on a hit locates the
// entry in the recency list, then closes the gap in that list. A flush walks the
// entries in index order and emits a writeback for each dirty one. After reset
// the block runs a clearing pass over all entries that loads the initial recency
// order, during which no request is accepted.
module lru_write_back_sector_cache
    import lruwb_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  logic [OP_W-1:0]     op,
    input  logic [SECTOR_W-1:0] sector,
    input  logic [LEN_W-1:0]    write_length,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [KIND_W-1:0]   kind,
    output logic [EIDX_W-1:0]   entry_index,
    output logic [SECTOR_W-1:0] target_sector,
    output logic                was_hit,
    output logic                last,
    output logic [CNT_W-1:0]    hit_total,
    output logic [CNT_W-1:0]    access_total
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef enum logic [14:0] {
        S_INIT     = 15'h0001,
        S_IDLE     = 15'h0002,
        S_SCAN     = 15'h0004,
        S_LRU_RD   = 15'h0008,
        S_VICTIM   = 15'h0010,
        S_TAG_RD   = 15'h0020,
        S_EVICT    = 15'h0040,
        S_FETCH    = 15'h0080,
        S_POS      = 15'h0100,
        S_SHIFT    = 15'h0200,
        S_CPL      = 15'h0400,
        S_FL_SCAN  = 15'h0800,
        S_FL_EMIT  = 15'h1000,
        S_DONE     = 15'h2000,
        S_SPARE    = 15'h4000
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     scan_reg, scan_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    op_t                  op_reg, op_next;
    logic [SECTOR_W-1:0]  sector_reg, sector_next;
    logic                 blind_reg, blind_next;
    logic                 hit_reg, hit_next;
    logic [ENTRIES-1:0]   valid_reg, valid_next;
    logic [ENTRIES-1:0]   dirty_reg, dirty_next;
    logic [CNT_W-1:0]     hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]     acc_cnt_reg, acc_cnt_next;

    logic                 rsp_valid_reg, rsp_valid_next;
    kind_t                rsp_kind_reg;
    logic [IDX_W-1:0]     rsp_idx_reg;
    logic [SECTOR_W-1:0]  rsp_sec_reg;
    logic                 rsp_hit_reg;
    logic                 rsp_last_reg;
    logic [CNT_W-1:0]     rsp_hit_cnt_reg;
    logic [CNT_W-1:0]     rsp_acc_cnt_reg;

    logic                 emit;
    kind_t                emit_kind;
    logic [IDX_W-1:0]     emit_idx;
    logic [SECTOR_W-1:0]  emit_sec;
    logic                 emit_hit;
    logic                 emit_last;
    logic                 emit_ok;

    logic                 tag_we;
    logic [SECTOR_W-1:0]  tag_rdata;
    logic                 order_we;
    logic [IDX_W-1:0]     order_waddr;
    logic [IDX_W-1:0]     order_wdata;
    logic [IDX_W-1:0]     order_rdata;

    logic [IDX_W-1:0]     scan_inc;
    logic [SECTOR_W-1:0]  cmp_a;
    logic [SECTOR_W-1:0]  cmp_b;
    logic                 cmp_eq;
    logic                 match;
    logic                 flush_last;

    // Both RAMs are always read at the scan pointer.
    lruwb_ram #(
        .WIDTH (SECTOR_W),
        .DEPTH (ENTRIES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (idx_reg),
        .wdata (sector_reg),
        .raddr (scan_reg),
        .rdata (tag_rdata)
    );

    lruwb_ram #(
        .WIDTH (IDX_W),
        .DEPTH (ENTRIES)
    ) u_order_ram (
        .clk   (clk),
        .we    (order_we),
        .waddr (order_waddr),
        .wdata (order_wdata),
        .raddr (scan_reg),
        .rdata (order_rdata)
    );

    assign scan_inc = (scan_reg == LAST_IDX) ? '0 : scan_reg + IDX_W'(1);

    // The one comparator serves the tag search and the recency list search.
    assign cmp_a  = (state_reg == S_SCAN) ? tag_rdata : SECTOR_W'(order_rdata);
    assign cmp_b  = (state_reg == S_SCAN) ? sector_reg : SECTOR_W'(idx_reg);
    assign cmp_eq = (cmp_a == cmp_b);
    assign match  = cmp_vld_reg && cmp_eq &&
                    ((state_reg == S_POS) || valid_reg[cmp_idx_reg]);

    // Dirty entries are flushed in index order, so none left besides this one
    // means this writeback is the final response.
    assign flush_last = ((dirty_reg & ~(ENTRIES'(1) << scan_reg)) == '0);

    assign emit_ok   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        scan_next    = scan_reg;
        cmp_idx_next = cmp_idx_reg;
        cmp_vld_next = cmp_vld_reg;
        idx_next     = idx_reg;
        op_next      = op_reg;
        sector_next  = sector_reg;
        blind_next   = blind_reg;
        hit_next     = hit_reg;
        valid_next   = valid_reg;
        dirty_next   = dirty_reg;
        hit_cnt_next = hit_cnt_reg;
        acc_cnt_next = acc_cnt_reg;

        emit      = 1'b0;
        emit_kind = KIND_DONE;
        emit_idx  = '0;
        emit_sec  = '0;
        emit_hit  = 1'b0;
        emit_last = 1'b0;

        tag_we      = 1'b0;
        order_we    = 1'b0;
        order_waddr = scan_reg;
        order_wdata = scan_reg;

        unique case (state_reg)
            S_INIT:
            begin
                order_we  = 1'b1;
                scan_next = scan_inc;
                if (scan_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next     = op_t'(op);
                    sector_next = sector;
                    blind_next  = (op_t'(op) == OP_WRITE) &&
                                  (32'(write_length) == 32'(SECTOR_BYTES));
                    unique case (op_t'(op)) inside
                        OP_READ, OP_WRITE:
                        begin
                            acc_cnt_next = acc_cnt_reg + CNT_W'(1);
                            hit_next     = 1'b0;
                            scan_next    = '0;
                            cmp_vld_next = 1'b0;
                            state_next   = S_SCAN;
                        end
                        OP_FLUSH:
                        begin
                            scan_next = '0;
                            if (dirty_reg == '0)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FL_SCAN;
                            end
                        end
                        default:
                        begin
                            valid_next   = '0;
                            dirty_next   = '0;
                            hit_cnt_next = '0;
                            acc_cnt_next = '0;
                            state_next   = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                scan_next    = scan_inc;
                cmp_idx_next = scan_reg;
                cmp_vld_next = 1'b1;
                if (match)
                begin
                    idx_next     = cmp_idx_reg;
                    hit_next     = 1'b1;
                    hit_cnt_next = hit_cnt_reg + CNT_W'(1);
                    scan_next    = '0;
                    cmp_vld_next = 1'b0;
                    state_next   = S_POS;
                end
                else if (cmp_vld_reg && (cmp_idx_reg == LAST_IDX))
                begin
                    scan_next  = '0;
                    state_next = S_LRU_RD;
                end
            end

            S_LRU_RD:
            begin
                state_next = S_VICTIM;
            end

            S_VICTIM:
            begin
                idx_next   = order_rdata;
                scan_next  = order_rdata;
                state_next = S_TAG_RD;
            end

            S_TAG_RD:
            begin
                state_next = S_EVICT;
            end

            S_EVICT:
            begin
                if (!dirty_reg[idx_reg] || emit_ok)
                begin
                    if (dirty_reg[idx_reg])
                    begin
                        emit                = 1'b1;
                        emit_kind           = KIND_WB;
                        emit_idx            = idx_reg;
                        emit_sec            = tag_rdata;
                        dirty_next[idx_reg] = 1'b0;
                    end
                    tag_we              = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    state_next          = S_FETCH;
                end
            end

            S_FETCH:
            begin
                if (blind_reg || emit_ok)
                begin
                    if (!blind_reg)
                    begin
                        emit      = 1'b1;
                        emit_kind = KIND_FETCH;
                        emit_idx  = idx_reg;
                        emit_sec  = sector_reg;
                    end
                    // The victim was least recent, so the list closes up from slot one.
                    scan_next    = IDX_W'(1);
                    cmp_vld_next = 1'b0;
                    state_next   = S_SHIFT;
                end
            end

            S_POS:
            begin
                scan_next    = scan_inc;
                cmp_idx_next = scan_reg;
                cmp_vld_next = 1'b1;
                if (match)
                begin
                    cmp_vld_next = 1'b0;
                    if (cmp_idx_reg == LAST_IDX)
                    begin
                        state_next = S_CPL;
                    end
                    else
                    begin
                        scan_next  = cmp_idx_reg + IDX_W'(1);
                        state_next = S_SHIFT;
                    end
                end
            end

            S_SHIFT:
            begin
                // Read one slot ahead and write the slot below what arrives.
                scan_next    = scan_inc;
                cmp_idx_next = scan_reg;
                cmp_vld_next = 1'b1;
                if (cmp_vld_reg)
                begin
                    order_we    = 1'b1;
                    order_waddr = cmp_idx_reg - IDX_W'(1);
                    order_wdata = order_rdata;
                    if (cmp_idx_reg == LAST_IDX)
                    begin
                        state_next = S_CPL;
                    end
                end
            end

            S_CPL:
            begin
                order_we    = 1'b1;
                order_waddr = LAST_IDX;
                order_wdata = idx_reg;
                if (emit_ok)
                begin
                    emit      = 1'b1;
                    emit_kind = KIND_DONE;
                    emit_idx  = idx_reg;
                    emit_sec  = sector_reg;
                    emit_hit  = hit_reg;
                    emit_last = 1'b1;
                    if (op_reg == OP_WRITE)
                    begin
                        dirty_next[idx_reg] = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end

            S_FL_SCAN:
            begin
                if (dirty_reg[scan_reg])
                begin
                    state_next = S_FL_EMIT;
                end
                else
                begin
                    scan_next = scan_inc;
                end
            end

            S_FL_EMIT:
            begin
                if (emit_ok)
                begin
                    emit                 = 1'b1;
                    emit_kind            = KIND_WB;
                    emit_idx             = scan_reg;
                    emit_sec             = tag_rdata;
                    emit_last            = flush_last;
                    dirty_next[scan_reg] = 1'b0;
                    if (flush_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        scan_next  = scan_inc;
                        state_next = S_FL_SCAN;
                    end
                end
            end

            S_DONE:
            begin
                if (emit_ok)
                begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            scan_reg      <= '0;
            cmp_vld_reg   <= 1'b0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            hit_cnt_reg   <= '0;
            acc_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            cmp_vld_reg   <= cmp_vld_next;
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            hit_cnt_reg   <= hit_cnt_next;
            acc_cnt_reg   <= acc_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        idx_reg     <= idx_next;
        op_reg      <= op_next;
        sector_reg  <= sector_next;
        blind_reg   <= blind_next;
        hit_reg     <= hit_next;
        if (emit)
        begin
            rsp_kind_reg    <= emit_kind;
            rsp_idx_reg     <= emit_idx;
            rsp_sec_reg     <= emit_sec;
            rsp_hit_reg     <= emit_hit;
            rsp_last_reg    <= emit_last;
            rsp_hit_cnt_reg <= hit_cnt_reg;
            rsp_acc_cnt_reg <= acc_cnt_reg;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign kind          = rsp_kind_reg;
    assign entry_index   = EIDX_W'(rsp_idx_reg);
    assign target_sector = rsp_sec_reg;
    assign was_hit       = rsp_hit_reg;
    assign last          = rsp_last_reg;
    assign hit_total     = rsp_hit_cnt_reg;
    assign access_total  = rsp_acc_cnt_reg;

endmodule

// ----- rtl/core/lruwb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lruwb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/lruwb_checker.sv -----
// Port-level assertion checker for the sector cache, bound to its top level.
`timescale 1ns / 1ps
`include "lru_write_back_sector_cache_defines.svh"

module lruwb_checker
    import lruwb_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input logic [KIND_W-1:0]   kind,
    input logic [EIDX_W-1:0]   entry_index,
    input logic [SECTOR_W-1:0] target_sector,
    input logic                was_hit,
    input logic                last,
    input logic [CNT_W-1:0]    hit_total,
    input logic [CNT_W-1:0]    access_total
);

    // A stalled response must hold its kind, index, sector, last flag and totals.
    `LRUWB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(kind) && $stable(entry_index) && $stable(target_sector) && $stable(last) && $stable(hit_total) && $stable(access_total), "stalled response changed")

    // A fetch is never last, since the completion of the same request follows it, and never reports a hit.
    `LRUWB_ASSERT_NOW(a_fetch_not_last, rsp_valid && (kind == KIND_FETCH), !last && !was_hit, "fetch marked last or hit")

    // Completions and done responses always close a request.
    `LRUWB_ASSERT_NOW(a_done_last, rsp_valid && (kind == KIND_DONE), last, "completion not marked last")

    // Only a completion can report a hit.
    `LRUWB_ASSERT_NOW(a_hit_on_cpl, rsp_valid && was_hit, kind == KIND_DONE, "hit flag on a command")

endmodule

bind lru_write_back_sector_cache lruwb_checker u_lruwb_checker (.*);
